// ===== src/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int LENGTH_BITS = 64;

  // parse phase codes
  localparam logic [2:0] PH_HDR0   = 3'd0;
  localparam logic [2:0] PH_HDR1   = 3'd1;
  localparam logic [2:0] PH_EXT    = 3'd2;
  localparam logic [2:0] PH_MASK   = 3'd3;
  localparam logic [2:0] PH_PAY    = 3'd4;
  localparam logic [2:0] PH_CLOSED = 3'd5;

  // opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT_BYTES16 = 4'd2;
  localparam logic [3:0] EXT_BYTES64 = 4'd8;

  // output word kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PONG  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  typedef logic [LENGTH_BITS-1:0] len_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

// ===== src/wsd_parser.sv =====
// Frame header/payload parser: state registers and per-byte result logic.
`timescale 1ns / 1ps

module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_acc,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  logic [2:0]  phase_r,   phase_nxt;
  logic [3:0]  opcode_r,  opcode_nxt;
  logic        mask_on_r, mask_on_nxt;
  len_t        len_r,     len_nxt;
  logic [3:0]  ext_cnt_r, ext_cnt_nxt;
  logic [31:0] mask_r,    mask_nxt;
  logic [1:0]  mpos_r,    mpos_nxt;

  logic [7:0]  key;
  logic        is_data;
  len_t        len_dec;
  res_t        fin_res;
  logic [2:0]  fin_phase;

  assign is_data = (opcode_r == OP_CONT) || (opcode_r == OP_BIN);
  assign len_dec = len_r - len_t'(1);

  always_comb begin
    unique case (mpos_r)
      2'd0: key = mask_r[31:24];
      2'd1: key = mask_r[23:16];
      2'd2: key = mask_r[15:8];
      default: key = mask_r[7:0];
    endcase
    if (!mask_on_r) key = 8'h00;
  end

  // end of a frame: ping and close raise events, close locks the parser
  always_comb begin
    fin_res   = '0;
    fin_phase = PH_HDR0;
    if (opcode_r == OP_PING) begin
      fin_res.vld  = 1'b1;
      fin_res.kind = KIND_PONG;
      fin_res.last = 1'b1;
    end else if (opcode_r == OP_CLOSE) begin
      fin_res.vld  = 1'b1;
      fin_res.kind = KIND_CLOSE;
      fin_res.last = 1'b1;
      fin_phase    = PH_CLOSED;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    opcode_nxt  = opcode_r;
    mask_on_nxt = mask_on_r;
    len_nxt     = len_r;
    ext_cnt_nxt = ext_cnt_r;
    mask_nxt    = mask_r;
    mpos_nxt    = mpos_r;
    res         = '0;
    if (byte_acc) begin
      unique case (phase_r)
        PH_CLOSED: begin
        end
        PH_HDR1: begin
          mask_on_nxt = rx_byte[7];
          if (rx_byte[6:0] == LEN7_EXT16) begin
            len_nxt     = '0;
            ext_cnt_nxt = EXT_BYTES16;
            phase_nxt   = PH_EXT;
          end else if (rx_byte[6:0] == LEN7_EXT64) begin
            len_nxt     = '0;
            ext_cnt_nxt = EXT_BYTES64;
            phase_nxt   = PH_EXT;
          end else begin
            len_nxt     = len_t'(rx_byte[6:0]);
            ext_cnt_nxt = '0;
            mpos_nxt    = '0;
            if (rx_byte[7]) begin
              mask_nxt  = '0;
              phase_nxt = PH_MASK;
            end else if (rx_byte[6:0] == 7'd0) begin
              res       = fin_res;
              phase_nxt = fin_phase;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
        end
        PH_EXT: begin
          // lengths beyond the counter width saturate
          if (len_r[LENGTH_BITS-1 -: 8] != 8'h00) len_nxt = '1;
          else len_nxt = {len_r[LENGTH_BITS-9:0], rx_byte};
          ext_cnt_nxt = ext_cnt_r - 4'd1;
          if (ext_cnt_r == 4'd1) begin
            mpos_nxt = '0;
            if (mask_on_r) begin
              mask_nxt  = '0;
              phase_nxt = PH_MASK;
            end else if (len_nxt == '0) begin
              res       = fin_res;
              phase_nxt = fin_phase;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
        end
        PH_MASK: begin
          mask_nxt = {mask_r[23:0], rx_byte};
          mpos_nxt = mpos_r + 2'd1;
          if (mpos_r == 2'd3) begin
            if (len_r == '0) begin
              res       = fin_res;
              phase_nxt = fin_phase;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          mpos_nxt = mpos_r + 2'd1;
          len_nxt  = len_dec;
          if (is_data) begin
            res.vld  = 1'b1;
            res.kind = KIND_DATA;
            res.data = rx_byte ^ key;
            res.last = (len_dec == '0);
            if (len_dec == '0) phase_nxt = PH_HDR0;
          end else if (len_dec == '0) begin
            res       = fin_res;
            phase_nxt = fin_phase;
          end
        end
        default: begin
          // first header byte; unused codes land here too
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      opcode_r  <= '0;
      mask_on_r <= 1'b0;
      len_r     <= '0;
      ext_cnt_r <= '0;
      mask_r    <= '0;
      mpos_r    <= '0;
    end else begin
      phase_r   <= phase_nxt;
      opcode_r  <= opcode_nxt;
      mask_on_r <= mask_on_nxt;
      len_r     <= len_nxt;
      ext_cnt_r <= ext_cnt_nxt;
      mask_r    <= mask_nxt;
      mpos_r    <= mpos_nxt;
    end
  end

  // once closed, the parser stays closed until reset
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CLOSED |=> phase_r == PH_CLOSED)
    else $error("closed state left without reset");

  // extended length counter only runs while reading length bytes
  a_ext_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_EXT |-> ext_cnt_r != 4'd0)
    else $error("extended length count empty in length phase");

  // a frame ends only after the payload counter has drained
  a_pay_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> len_r != '0)
    else $error("payload phase with zero length left");

endmodule

// ===== src/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket frame deframer: stream ports and output register.
// Output: a result word appears in the cycle after the byte that causes it is taken.
// Throughput: one received byte per cycle; the output register refills in the
// same cycle that its word is taken, so only downstream back-pressure stalls input.
// Reset: synchronous, active low; parser returns to the first header byte,
// the output register empties and any close lock is released.
`timescale 1ns / 1ps

module websocket_frame_deframer_top
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast
);

  logic       in_acc;
  res_t       res;
  logic       vld_r;
  logic [7:0] data_r;
  logic [1:0] kind_r;
  logic       last_r;

  assign in_tready = !vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  wsd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (in_acc),
    .rx_byte  (in_tdata),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_acc && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res.vld) begin
      data_r <= res.data;
      kind_r <= res.kind;
      last_r <= res.last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_DATA || out_tuser == KIND_PONG ||
                    out_tuser == KIND_CLOSE))
    else $error("undefined output kind");

  a_event_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tdata == 8'h00 && out_tlast)
    else $error("event word with data or without last");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

endmodule
